@@ hw/rtl/mialu_pkg.sv @@
// shared types and operation codes for the integer alu with hi/lo accumulator
package mialu_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned AccWidth = 64;
   localparam int unsigned CmdWidth = 6;
   localparam int unsigned ShiftImmWidth = 8;
   localparam int unsigned ReqDataWidth = 144;
   localparam int unsigned RspDataWidth = 40;

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD    = 6'd0,
      CMD_SUB    = 6'd1,
      CMD_ADDC   = 6'd2,
      CMD_SUBC   = 6'd3,
      CMD_NEG    = 6'd4,
      CMD_MOV    = 6'd5,
      CMD_EXT8   = 6'd6,
      CMD_EXT16  = 6'd7,
      CMD_BSWAP  = 6'd8,
      CMD_SLT    = 6'd9,
      CMD_SLTC   = 6'd10,
      CMD_SLTU   = 6'd11,
      CMD_SLTUC  = 6'd12,
      CMD_MOVZ   = 6'd13,
      CMD_MOVNZ  = 6'd14,
      CMD_MAX    = 6'd15,
      CMD_MIN    = 6'd16,
      CMD_MTLO   = 6'd17,
      CMD_MTHI   = 6'd18,
      CMD_MFLO   = 6'd19,
      CMD_MFHI   = 6'd20,
      CMD_AND    = 6'd21,
      CMD_OR     = 6'd22,
      CMD_XOR    = 6'd23,
      CMD_ANDC   = 6'd24,
      CMD_ORC    = 6'd25,
      CMD_MULT   = 6'd26,
      CMD_MULTU  = 6'd27,
      CMD_MADD   = 6'd28,
      CMD_MADDU  = 6'd29,
      CMD_MSUB   = 6'd30,
      CMD_MSUBU  = 6'd31,
      CMD_SHL    = 6'd32,
      CMD_SHR    = 6'd33,
      CMD_SAR    = 6'd34,
      CMD_ROR    = 6'd35,
      CMD_SHLI   = 6'd36,
      CMD_SHRI   = 6'd37,
      CMD_SARI   = 6'd38,
      CMD_RORI   = 6'd39
   } cmd_type;

   typedef struct packed {
      cmd_type                   command;
      logic [DataWidth-1:0]      operand_a;
      logic [DataWidth-1:0]      operand_b;
      logic [DataWidth-1:0]      dest_old;
      logic [DataWidth-1:0]      immediate;
      logic [ShiftImmWidth-1:0]  shift_imm;
   } req_type;

   typedef struct packed {
      cmd_type                   command;
      logic [DataWidth-1:0]      operand_a;
      logic [AccWidth-1:0]       product;
      logic [DataWidth-1:0]      result;
      logic                      writes_dest;
   } mid_type;

endpackage

@@ hw/rtl/mialu_exec.sv @@
// register-result operations and the 33x33 multiplier for one item
module mialu_exec (
   input  mialu_pkg::req_type item,
   output mialu_pkg::mid_type mid
);

   logic [mialu_pkg::DataWidth-1:0] a;
   logic [mialu_pkg::DataWidth-1:0] b;
   logic [4:0]                      sb;
   logic [4:0]                      si_rot;
   logic                            si_big;
   logic [4:0]                      si_sar;
   logic                            mul_signed;
   logic signed [32:0]              mul_a;
   logic signed [32:0]              mul_b;
   logic signed [65:0]              mul_full;
   logic [2*mialu_pkg::DataWidth-1:0] rot_b;
   logic [2*mialu_pkg::DataWidth-1:0] rot_i;
   logic [mialu_pkg::DataWidth-1:0] r;
   logic                            wr;

   assign a = item.operand_a;
   assign b = item.operand_b;
   assign sb = b[4:0];
   assign si_rot = item.shift_imm[4:0];
   assign si_big = |item.shift_imm[7:5];
   assign si_sar = si_big ? 5'd31 : item.shift_imm[4:0];

   // odd codes of the multiply group are unsigned
   assign mul_signed = ~item.command[0];
   assign mul_a = $signed({mul_signed & a[31], a});
   assign mul_b = $signed({mul_signed & b[31], b});
   assign mul_full = mul_a * mul_b;

   assign rot_b = {a, a} >> sb;
   assign rot_i = {a, a} >> si_rot;

   always_comb begin
      r = '0;
      wr = 1'b1;
      unique case (item.command)
         mialu_pkg::CMD_ADD:   r = a + b;
         mialu_pkg::CMD_SUB:   r = a - b;
         mialu_pkg::CMD_ADDC:  r = a + item.immediate;
         mialu_pkg::CMD_SUBC:  r = a - item.immediate;
         mialu_pkg::CMD_NEG:   r = '0 - a;
         mialu_pkg::CMD_MOV:   r = a;
         mialu_pkg::CMD_EXT8:  r = {{24{a[7]}}, a[7:0]};
         mialu_pkg::CMD_EXT16: r = {{16{a[15]}}, a[15:0]};
         mialu_pkg::CMD_BSWAP: r = {a[7:0], a[15:8], a[23:16], a[31:24]};
         mialu_pkg::CMD_SLT:   r = {31'd0, $signed(a) < $signed(b)};
         mialu_pkg::CMD_SLTC:  r = {31'd0, $signed(a) < $signed(item.immediate)};
         mialu_pkg::CMD_SLTU:  r = {31'd0, a < b};
         mialu_pkg::CMD_SLTUC: r = {31'd0, a < item.immediate};
         mialu_pkg::CMD_MOVZ:  r = (a == '0) ? b : item.dest_old;
         mialu_pkg::CMD_MOVNZ: r = (a != '0) ? b : item.dest_old;
         mialu_pkg::CMD_MAX:   r = ($signed(a) < $signed(b)) ? b : a;
         mialu_pkg::CMD_MIN:   r = ($signed(b) < $signed(a)) ? b : a;
         mialu_pkg::CMD_MTLO,
         mialu_pkg::CMD_MTHI,
         mialu_pkg::CMD_MULT,
         mialu_pkg::CMD_MULTU,
         mialu_pkg::CMD_MADD,
         mialu_pkg::CMD_MADDU,
         mialu_pkg::CMD_MSUB,
         mialu_pkg::CMD_MSUBU: wr = 1'b0;
         // value filled in by the accumulator stage
         mialu_pkg::CMD_MFLO,
         mialu_pkg::CMD_MFHI:  r = '0;
         mialu_pkg::CMD_AND:   r = a & b;
         mialu_pkg::CMD_OR:    r = a | b;
         mialu_pkg::CMD_XOR:   r = a ^ b;
         mialu_pkg::CMD_ANDC:  r = a & item.immediate;
         mialu_pkg::CMD_ORC:   r = a | item.immediate;
         mialu_pkg::CMD_SHL:   r = a << sb;
         mialu_pkg::CMD_SHR:   r = a >> sb;
         mialu_pkg::CMD_SAR:   r = $unsigned($signed(a) >>> sb);
         mialu_pkg::CMD_ROR:   r = rot_b[31:0];
         mialu_pkg::CMD_SHLI:  r = si_big ? '0 : (a << item.shift_imm[4:0]);
         mialu_pkg::CMD_SHRI:  r = si_big ? '0 : (a >> item.shift_imm[4:0]);
         mialu_pkg::CMD_SARI:  r = $unsigned($signed(a) >>> si_sar);
         mialu_pkg::CMD_RORI:  r = rot_i[31:0];
         default:              wr = 1'b0;
      endcase
   end

   assign mid.command = item.command;
   assign mid.operand_a = a;
   assign mid.product = mul_full[63:0];
   assign mid.result = r;
   assign mid.writes_dest = wr;

endmodule

@@ hw/rtl/mialu_acc.sv @@
// hi:lo accumulator register with multiply-accumulate and move operations
module mialu_acc (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  mialu_pkg::mid_type                mid,
   output logic [mialu_pkg::DataWidth-1:0]   result,
   output logic                              writes_dest
);

   logic [mialu_pkg::AccWidth-1:0] acc_ff;
   logic [mialu_pkg::AccWidth-1:0] acc_in;

   always_comb begin
      acc_in = acc_ff;
      result = mid.result;
      unique case (mid.command)
         mialu_pkg::CMD_MULT,
         mialu_pkg::CMD_MULTU: acc_in = mid.product;
         mialu_pkg::CMD_MADD,
         mialu_pkg::CMD_MADDU: acc_in = acc_ff + mid.product;
         mialu_pkg::CMD_MSUB,
         mialu_pkg::CMD_MSUBU: acc_in = acc_ff - mid.product;
         mialu_pkg::CMD_MTLO:  acc_in = {acc_ff[63:32], mid.operand_a};
         mialu_pkg::CMD_MTHI:  acc_in = {mid.operand_a, acc_ff[31:0]};
         mialu_pkg::CMD_MFLO:  result = acc_ff[31:0];
         mialu_pkg::CMD_MFHI:  result = acc_ff[63:32];
         default:              acc_in = acc_ff;
      endcase
   end

   assign writes_dest = mid.writes_dest;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (advance) begin
         acc_ff <= acc_in;
      end
   end

endmodule

@@ hw/rtl/mips_integer_alu_hilo_top.sv @@
// top level of the integer alu with hi:lo multiply-accumulate
//
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | command, operand_a/b, dest_old, immediate, shift_imm
// rsp     | out | rsp_tvalid/tready   | result, writes_dest
//
// three register stages: input, execute (alu and multiplier), accumulate/output
// one item per cycle sustained while rsp_tready stays high
// the multiplier sets the execute stage, the 64-bit add sets the accumulate stage
// each stage holds its item while the next one is full and stalled, so bubbles close up
// reset clears all valid bits and the hi:lo accumulator
module mips_integer_alu_hilo_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // command[5:0], operand_a[37:6], operand_b[69:38], dest_old[101:70],
   // immediate[133:102], shift_imm[141:134], zero fill
   input  logic [mialu_pkg::ReqDataWidth-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result[31:0], writes_dest[32], zero fill
   output logic [mialu_pkg::RspDataWidth-1:0]   rsp_tdata
);

   mialu_pkg::req_type                in_item;
   mialu_pkg::req_type                in_item_ff;
   logic                              in_vld_ff;
   mialu_pkg::mid_type                mid_in;
   mialu_pkg::mid_type                mid_ff;
   logic                              mid_vld_ff;
   logic [mialu_pkg::DataWidth-1:0]   out_result_in;
   logic                              out_wr_in;
   logic [mialu_pkg::DataWidth-1:0]   out_result_ff;
   logic                              out_wr_ff;
   logic                              out_vld_ff;
   logic                              out_rdy;
   logic                              mid_rdy;
   logic                              in_rdy;
   logic                              mid_fire;
   logic                              in_fire;
   logic                              req_fire;

   assign in_item.command   = mialu_pkg::cmd_type'(req_tdata[5:0]);
   assign in_item.operand_a = req_tdata[37:6];
   assign in_item.operand_b = req_tdata[69:38];
   assign in_item.dest_old  = req_tdata[101:70];
   assign in_item.immediate = req_tdata[133:102];
   assign in_item.shift_imm = req_tdata[141:134];

   assign out_rdy  = ~out_vld_ff | rsp_tready;
   assign mid_rdy  = ~mid_vld_ff | out_rdy;
   assign in_rdy   = ~in_vld_ff | mid_rdy;
   assign mid_fire = mid_vld_ff & out_rdy;
   assign in_fire  = in_vld_ff & mid_rdy;
   assign req_fire = req_tvalid & in_rdy;

   assign req_tready = in_rdy;

   mialu_exec u_exec (
      .item (in_item_ff),
      .mid  (mid_in)
   );

   mialu_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .advance     (mid_fire),
      .mid         (mid_ff),
      .result      (out_result_in),
      .writes_dest (out_wr_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mid_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (in_rdy) begin
            in_vld_ff <= req_tvalid;
         end
         if (mid_rdy) begin
            mid_vld_ff <= in_vld_ff;
         end
         if (out_rdy) begin
            out_vld_ff <= mid_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item;
      end
      if (in_fire) begin
         mid_ff <= mid_in;
      end
      if (mid_fire) begin
         out_result_ff <= out_result_in;
         out_wr_ff     <= out_wr_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_wr_ff, out_result_ff};

`ifndef ASSERT_OFF
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> in_vld_ff)
      else $error("accepted item not held in input stage");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      out_rdy && !mid_vld_ff |=> !rsp_tvalid)
      else $error("result shown with no item behind it");

   a_acc_no_write: assert property (@(posedge clock) disable iff (reset)
      mid_fire && (mid_ff.command == mialu_pkg::CMD_MADD ||
                   mid_ff.command == mialu_pkg::CMD_MSUB ||
                   mid_ff.command == mialu_pkg::CMD_MULT ||
                   mid_ff.command == mialu_pkg::CMD_MTLO) |=> !rsp_tdata[32])
      else $error("accumulator operation marked as destination write");
`endif

endmodule
